FILE: hdl/jhp_pkg.sv
// ----------------------------------------------------------------------------
// jhp_pkg
// Shared constants, status codes and controller/datapath interface types
// for the JPEG header parser with prefix lookup table.
// ----------------------------------------------------------------------------
package jhp_pkg;

	localparam int LOOKUP_BITS_DEF = 8;
	localparam int MAX_SYMBOLS_DEF = 256;

	localparam logic [2:0] ST_READY     = 3'd0;
	localparam logic [2:0] ST_NO_SOI    = 3'd1;
	localparam logic [2:0] ST_BAD_COUNT = 3'd2;
	localparam logic [2:0] ST_EOI       = 3'd3;
	localparam logic [2:0] ST_BAD_MARK  = 3'd4;
	localparam logic [2:0] ST_ZERO_SIZE = 3'd5;
	localparam logic [2:0] ST_TRUNC     = 3'd6;
	localparam logic [2:0] ST_ENTRY     = 3'd7;

	typedef enum logic [2:0] {
		SEG_HOLD,
		SEG_HI,
		SEG_LO_SUB2,
		SEG_DEC,
		SEG_SOF,
		SEG_SOS
	} seg_op_t;

	typedef struct packed {
		seg_op_t    seg_op;
		logic       ld_prec;
		logic       ld_h_hi;
		logic       ld_h_lo;
		logic       ld_w_hi;
		logic       ld_w_lo;
		logic       ld_nc;
		logic       dht_begin;
		logic       wr_count;
		logic       init_syms;
		logic       ld_sym;
		logic       adv_step;
		logic       fill_start;
		logic       fill_step;
		logic       sym_done;
		logic       ram_rd;
		logic       ld_out;
		logic       out_entry;
		logic [2:0] out_status;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
		logic seg_zero;
		logic seg_dec_zero;
		logic seg_lo_zero;
		logic cnt_last;
		logic sum_bad;
		logic sum_zero;
		logic syms_dec_zero;
		logic adv_more;
		logic fill_ok;
		logic fill_last;
		logic dim_zero;
	} sts_t;

endpackage

FILE: hdl/jpeg_header_parser_huffman_lut.sv
// ----------------------------------------------------------------------------
// jpeg_header_parser_huffman_lut
// Byte-serial JPEG marker parser with an 8-bit prefix Huffman lookup table.
// ----------------------------------------------------------------------------
// A stream byte's result is registered in the cycle after the byte is taken.
// A table read goes through the registered RAM port, then E_READ loads the
// result register. A DHT symbol byte is followed by code length steps (up to
// 16) and 2^(LOOKUP_BITS-len) writes through the table RAM's single write port.
// One item at a time; taken only when idle and the result register is empty.
// Reset: parser expects SOI, frame registers zero, table contents undefined.
module jpeg_header_parser_huffman_lut #(
	parameter int LOOKUP_BITS = jhp_pkg::LOOKUP_BITS_DEF,
	parameter int MAX_SYMBOLS = jhp_pkg::MAX_SYMBOLS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        action,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] frame_width,
	output logic [15:0] frame_height,
	output logic [7:0]  sample_precision,
	output logic [7:0]  component_count,
	output logic [3:0]  entry_code_length,
	output logic [7:0]  entry_symbol
);

	jhp_pkg::cmd_t cmd;
	jhp_pkg::sts_t sts;

	jhp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.action    (action),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.sts       (sts),
		.cmd       (cmd)
	);

	jhp_dp #(
		.LOOKUP_BITS (LOOKUP_BITS),
		.MAX_SYMBOLS (MAX_SYMBOLS)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.data_byte         (data_byte),
		.out_ready         (out_ready),
		.out_valid         (out_valid),
		.status            (status),
		.frame_width       (frame_width),
		.frame_height      (frame_height),
		.sample_precision  (sample_precision),
		.component_count   (component_count),
		.entry_code_length (entry_code_length),
		.entry_symbol      (entry_symbol)
	);

	a_ready_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid)
		else $error("input taken while a result is pending");

	a_fill_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fill_step |-> !in_ready)
		else $error("table fill while accepting items");

	a_entry_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status != jhp_pkg::ST_ENTRY) |->
		(entry_code_length == 4'd0 && entry_symbol == 8'd0))
		else $error("entry fields set in a parse result");

endmodule

FILE: hdl/jhp_ram.sv
// ----------------------------------------------------------------------------
// jhp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module jhp_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: hdl/jhp_dp.sv
// ----------------------------------------------------------------------------
// jhp_dp
// Parser datapath: segment counter, frame registers, DHT code builder,
// lookup table fill and the result register.
// ----------------------------------------------------------------------------
module jhp_dp #(
	parameter int LOOKUP_BITS = jhp_pkg::LOOKUP_BITS_DEF,
	parameter int MAX_SYMBOLS = jhp_pkg::MAX_SYMBOLS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  jhp_pkg::cmd_t cmd,
	output jhp_pkg::sts_t sts,
	input  logic [7:0]    data_byte,
	input  logic          out_ready,
	output logic          out_valid,
	output logic [2:0]    status,
	output logic [15:0]   frame_width,
	output logic [15:0]   frame_height,
	output logic [7:0]    sample_precision,
	output logic [7:0]    component_count,
	output logic [3:0]    entry_code_length,
	output logic [7:0]    entry_symbol
);

	localparam int SW = $clog2(MAX_SYMBOLS + 1);
	localparam int LB = LOOKUP_BITS;

	logic [15:0]   seg_q, seg_d, lo_val, lo_sub;
	logic [15:0]   w_q, w_d, h_q, h_d;
	logic [7:0]    p_q, p_d, c_q, c_d;
	logic [7:0]    cnt_q [16];
	logic [3:0]    cnt_idx_q;
	logic [11:0]   acc_q, acc_nx;
	logic          ac_q;
	logic [SW-1:0] syms_q;
	logic [15:0]   code_q;
	logic [4:0]    len_q;
	logic [7:0]    group_q;
	logic [7:0]    sym_q;
	logic [LB-1:0] fill_i_q, mask, base;
	logic [4:0]    sh;
	logic [11:0]   rdata;

	assign lo_val = {seg_q[15:8], data_byte};
	assign lo_sub = (lo_val >= 16'd2) ? lo_val - 16'd2 : 16'd0;
	assign acc_nx = acc_q + {4'd0, data_byte};

	always_comb begin
		case (cmd.seg_op)
			jhp_pkg::SEG_HI:      seg_d = {data_byte, 8'd0};
			jhp_pkg::SEG_LO_SUB2: seg_d = lo_sub;
			jhp_pkg::SEG_DEC:     seg_d = (seg_q != 16'd0) ? seg_q - 16'd1 : 16'd0;
			jhp_pkg::SEG_SOF:     seg_d = {8'd0, data_byte} * 16'd3;
			jhp_pkg::SEG_SOS:     seg_d = {7'd0, data_byte, 1'b0} + 16'd3;
			default:              seg_d = seg_q;
		endcase
	end

	// next values of the frame registers; a result shows them after this item
	always_comb begin
		w_d = w_q;
		h_d = h_q;
		p_d = p_q;
		c_d = c_q;
		if (cmd.ld_prec) p_d = data_byte;
		if (cmd.ld_h_hi) h_d = {data_byte, 8'd0};
		if (cmd.ld_h_lo) h_d = {h_q[15:8], data_byte};
		if (cmd.ld_w_hi) w_d = {data_byte, 8'd0};
		if (cmd.ld_w_lo) w_d = {w_q[15:8], data_byte};
		if (cmd.ld_nc)   c_d = data_byte;
	end

	assign sh   = 5'(LB) - len_q;
	assign mask = {LB{1'b1}} >> len_q;
	assign base = code_q[LB-1:0] << sh;

	assign sts.out_busy      = out_valid;
	assign sts.seg_zero      = (seg_q == 16'd0);
	assign sts.seg_dec_zero  = (seg_q <= 16'd1);
	assign sts.seg_lo_zero   = (lo_sub == 16'd0);
	assign sts.cnt_last      = (cnt_idx_q == 4'd15);
	assign sts.sum_bad       = (acc_nx > 12'(MAX_SYMBOLS));
	assign sts.sum_zero      = (acc_nx == 12'd0);
	assign sts.syms_dec_zero = (syms_q <= SW'(1));
	assign sts.adv_more      = (group_q == 8'd0) && (len_q < 5'd16);
	assign sts.fill_ok       = !ac_q && (len_q >= 5'd1) && (len_q <= 5'(LB))
		&& ((code_q >> len_q) == 16'd0);
	assign sts.fill_last     = (fill_i_q == mask);
	assign sts.dim_zero      = (w_q == 16'd0) || (h_q == 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q     <= '0;
			w_q       <= '0;
			h_q       <= '0;
			p_q       <= '0;
			c_q       <= '0;
			syms_q    <= '0;
			code_q    <= '0;
			len_q     <= '0;
			group_q   <= '0;
			ac_q      <= 1'b0;
			cnt_idx_q <= '0;
			acc_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			seg_q <= seg_d;
			w_q   <= w_d;
			h_q   <= h_d;
			p_q   <= p_d;
			c_q   <= c_d;
			if (cmd.dht_begin) begin
				ac_q      <= data_byte[4];
				cnt_idx_q <= '0;
				acc_q     <= '0;
			end
			if (cmd.wr_count) begin
				cnt_idx_q <= cnt_idx_q + 4'd1;
				acc_q     <= acc_nx;
			end
			if (cmd.init_syms) begin
				syms_q  <= SW'(acc_nx);
				code_q  <= '0;
				len_q   <= '0;
				group_q <= '0;
			end
			if (cmd.adv_step) begin
				len_q   <= len_q + 5'd1;
				code_q  <= {code_q[14:0], 1'b0};
				group_q <= cnt_q[len_q[3:0]];
			end
			if (cmd.sym_done) begin
				code_q <= code_q + 16'd1;
				if (group_q != 8'd0) group_q <= group_q - 8'd1;
				if (syms_q != '0) syms_q <= syms_q - SW'(1);
			end
			if (cmd.ld_out) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_count) cnt_q[cnt_idx_q] <= data_byte;
		if (cmd.ld_sym) sym_q <= data_byte;
		if (cmd.fill_start) fill_i_q <= '0;
		else if (cmd.fill_step) fill_i_q <= fill_i_q + LB'(1);
		if (cmd.ld_out) begin
			status            <= cmd.out_status;
			frame_width       <= w_d;
			frame_height      <= h_d;
			sample_precision  <= p_d;
			component_count   <= c_d;
			entry_code_length <= cmd.out_entry ? rdata[11:8] : 4'd0;
			entry_symbol      <= cmd.out_entry ? rdata[7:0] : 8'd0;
		end
	end

	jhp_ram #(
		.WIDTH (12),
		.DEPTH (2 ** LB)
	) u_table (
		.clk   (clk),
		.we    (cmd.fill_step),
		.waddr (base | fill_i_q),
		.wdata ({len_q[3:0], sym_q}),
		.re    (cmd.ram_rd),
		.raddr (LB'(data_byte)),
		.rdata (rdata)
	);

endmodule

FILE: hdl/jhp_ctrl.sv
// ----------------------------------------------------------------------------
// jhp_ctrl
// Parser controller: marker hunt and segment phases, plus the per-item
// sequencer for code length steps, table fill and table reads.
// ----------------------------------------------------------------------------
module jhp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          action,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  jhp_pkg::sts_t sts,
	output jhp_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		P_SOI0, P_SOI1_OK, P_SOI1_BAD, P_HUNT, P_FF,
		P_SKIP_HI, P_SKIP_LO, P_SKIP,
		P_SOF_LEN_HI, P_SOF_LEN_LO, P_SOF_PREC, P_SOF_H_HI, P_SOF_H_LO,
		P_SOF_W_HI, P_SOF_W_LO, P_SOF_NC, P_SOF_COMP,
		P_DHT_HI, P_DHT_LO, P_DHT_INDEX, P_DHT_COUNTS, P_DHT_SYMS,
		P_SOS_HI, P_SOS_LO, P_SOS_N, P_SOS_REST, P_DONE
	} phase_t;

	typedef enum logic [1:0] {E_IDLE, E_ADV, E_FILL, E_READ} exec_t;

	phase_t phase_q, phase_d;
	exec_t  exec_q, exec_d;
	logic   pass_q, pass_d;
	logic   last_q, last_d;
	logic   fire, emit, defer, sym_end;
	logic [2:0] st;

	assign in_ready = (exec_q == E_IDLE) && !sts.out_busy;
	assign fire     = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		cmd.seg_op = jhp_pkg::SEG_HOLD;
		phase_d = phase_q;
		exec_d  = exec_q;
		pass_d  = pass_q;
		last_d  = last_q;
		emit    = 1'b0;
		defer   = 1'b0;
		sym_end = 1'b0;
		st      = jhp_pkg::ST_READY;
		case (exec_q)
			E_IDLE: begin
				if (fire && action) begin
					cmd.ram_rd = 1'b1;
					exec_d     = E_READ;
				end else if (fire && phase_q == P_DONE) begin
					if (last_byte) phase_d = P_SOI0;
				end else if (fire) begin
					case (phase_q)
						P_SOI0: phase_d = (data_byte == 8'hFF) ? P_SOI1_OK : P_SOI1_BAD;
						P_SOI1_OK: begin
							if (data_byte != 8'hD8) begin
								emit = 1'b1;
								st   = jhp_pkg::ST_NO_SOI;
							end else begin
								pass_d  = 1'b0;
								phase_d = P_HUNT;
							end
						end
						P_SOI1_BAD: begin
							emit = 1'b1;
							st   = jhp_pkg::ST_NO_SOI;
						end
						P_HUNT: if (data_byte == 8'hFF) phase_d = P_FF;
						P_FF: begin
							if (data_byte == 8'h00) begin
								phase_d = P_HUNT;
							end else if (data_byte != 8'hFF) begin
								if ((data_byte inside {[8'hC0:8'hCF]} && data_byte != 8'hC4
									&& data_byte != 8'hCC)
									|| data_byte inside {8'hD8, 8'hD9, 8'hDA}) begin
									// frame-level marker
									if (!pass_q) begin
										if (data_byte inside {8'hC0, 8'hC1, 8'hC3}) begin
											phase_d = P_SOF_LEN_HI;
										end else begin
											pass_d  = 1'b1;
											phase_d = P_HUNT;
										end
									end else if (data_byte == 8'hDA) begin
										phase_d = P_SOS_HI;
									end else begin
										emit = 1'b1;
										st   = (data_byte == 8'hD9) ? jhp_pkg::ST_EOI
											: jhp_pkg::ST_BAD_MARK;
									end
								end else if (data_byte == 8'hC4) begin
									phase_d = P_DHT_HI;
								end else if (data_byte inside {8'hDB, [8'hD0:8'hD7], 8'h01}) begin
									phase_d = P_HUNT;
								end else begin
									phase_d = P_SKIP_HI;
								end
							end
						end
						P_SKIP_HI: begin
							cmd.seg_op = jhp_pkg::SEG_HI;
							phase_d    = P_SKIP_LO;
						end
						P_SKIP_LO: begin
							cmd.seg_op = jhp_pkg::SEG_LO_SUB2;
							phase_d    = sts.seg_lo_zero ? P_HUNT : P_SKIP;
						end
						P_SKIP, P_SOF_COMP: begin
							cmd.seg_op = jhp_pkg::SEG_DEC;
							if (sts.seg_dec_zero) phase_d = P_HUNT;
						end
						P_SOF_LEN_HI: phase_d = P_SOF_LEN_LO;
						P_SOF_LEN_LO: phase_d = P_SOF_PREC;
						P_SOF_PREC: begin
							cmd.ld_prec = 1'b1;
							phase_d     = P_SOF_H_HI;
						end
						P_SOF_H_HI: begin
							cmd.ld_h_hi = 1'b1;
							phase_d     = P_SOF_H_LO;
						end
						P_SOF_H_LO: begin
							cmd.ld_h_lo = 1'b1;
							phase_d     = P_SOF_W_HI;
						end
						P_SOF_W_HI: begin
							cmd.ld_w_hi = 1'b1;
							phase_d     = P_SOF_W_LO;
						end
						P_SOF_W_LO: begin
							cmd.ld_w_lo = 1'b1;
							phase_d     = P_SOF_NC;
						end
						P_SOF_NC: begin
							cmd.ld_nc  = 1'b1;
							cmd.seg_op = jhp_pkg::SEG_SOF;
							pass_d     = 1'b1;
							phase_d    = (data_byte == 8'd0) ? P_HUNT : P_SOF_COMP;
						end
						P_DHT_HI: begin
							cmd.seg_op = jhp_pkg::SEG_HI;
							phase_d    = P_DHT_LO;
						end
						P_DHT_LO: begin
							cmd.seg_op = jhp_pkg::SEG_LO_SUB2;
							phase_d    = sts.seg_lo_zero ? P_HUNT : P_DHT_INDEX;
						end
						P_DHT_INDEX: begin
							cmd.seg_op    = jhp_pkg::SEG_DEC;
							cmd.dht_begin = 1'b1;
							phase_d       = P_DHT_COUNTS;
						end
						P_DHT_COUNTS: begin
							cmd.seg_op   = jhp_pkg::SEG_DEC;
							cmd.wr_count = 1'b1;
							if (sts.cnt_last) begin
								if (sts.sum_bad) begin
									emit = 1'b1;
									st   = jhp_pkg::ST_BAD_COUNT;
								end else begin
									cmd.init_syms = 1'b1;
									if (sts.sum_zero) begin
										phase_d = sts.seg_dec_zero ? P_HUNT : P_DHT_INDEX;
									end else begin
										phase_d = P_DHT_SYMS;
									end
								end
							end
						end
						P_DHT_SYMS: begin
							cmd.seg_op = jhp_pkg::SEG_DEC;
							cmd.ld_sym = 1'b1;
							last_d     = last_byte;
							exec_d     = E_ADV;
							defer      = 1'b1;
						end
						P_SOS_HI: phase_d = P_SOS_LO;
						P_SOS_LO: phase_d = P_SOS_N;
						P_SOS_N: begin
							cmd.seg_op = jhp_pkg::SEG_SOS;
							phase_d    = P_SOS_REST;
						end
						P_SOS_REST: begin
							cmd.seg_op = jhp_pkg::SEG_DEC;
							if (sts.seg_dec_zero) begin
								emit = 1'b1;
								st   = sts.dim_zero ? jhp_pkg::ST_ZERO_SIZE : jhp_pkg::ST_READY;
							end
						end
						default: phase_d = P_SOI0;
					endcase
					if (emit) begin
						cmd.ld_out     = 1'b1;
						cmd.out_status = st;
						phase_d        = last_byte ? P_SOI0 : P_DONE;
					end else if (!defer && last_byte) begin
						cmd.ld_out     = 1'b1;
						cmd.out_status = jhp_pkg::ST_TRUNC;
						phase_d        = P_SOI0;
					end
				end
			end
			E_ADV: begin
				// walk to the next nonempty code length, one length per cycle
				if (sts.adv_more) begin
					cmd.adv_step = 1'b1;
				end else if (sts.fill_ok) begin
					cmd.fill_start = 1'b1;
					exec_d         = E_FILL;
				end else begin
					sym_end = 1'b1;
				end
			end
			E_FILL: begin
				cmd.fill_step = 1'b1;
				if (sts.fill_last) sym_end = 1'b1;
			end
			E_READ: begin
				cmd.ld_out     = 1'b1;
				cmd.out_entry  = 1'b1;
				cmd.out_status = jhp_pkg::ST_ENTRY;
				exec_d         = E_IDLE;
			end
			default: exec_d = E_IDLE;
		endcase
		if (sym_end) begin
			cmd.sym_done = 1'b1;
			exec_d       = E_IDLE;
			if (sts.syms_dec_zero) phase_d = sts.seg_zero ? P_HUNT : P_DHT_INDEX;
			if (last_q) begin
				cmd.ld_out     = 1'b1;
				cmd.out_status = jhp_pkg::ST_TRUNC;
				phase_d        = P_SOI0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= P_SOI0;
			exec_q  <= E_IDLE;
			pass_q  <= 1'b0;
			last_q  <= 1'b0;
		end else begin
			phase_q <= phase_d;
			exec_q  <= exec_d;
			pass_q  <= pass_d;
			last_q  <= last_d;
		end
	end

endmodule
